FILE: src/spring_mass_velocity_step_unit_macros.svh
// Assertion macros shared by the spring mass step unit
`ifndef SPRING_MASS_VELOCITY_STEP_UNIT_MACROS_SVH
`define SPRING_MASS_VELOCITY_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define SMVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/smvs_pkg.sv
// Constants, types and helpers of the spring mass step unit
package smvs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_FRAC   = 16;
    localparam int KDT_SHIFT = 8;

    localparam int POS_W  = 32;
    localparam int DT_W   = 16;
    localparam int K_W    = 16;
    localparam int REST_W = 31;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_LINK    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_RELOAD  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 2'd2;
    localparam logic [DT_W-1:0] STEP_TIME_RESET = 16'd1092;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W - DT_FRAC;
    localparam int KDT_W   = K_W + DT_W - KDT_SHIFT;
    localparam int EXT_W   = MUL_A_W;

    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 64;
    localparam int REM_W     = 34;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int UNIT_W    = FRAC_BITS + 2;
    localparam int CNT_W     = 5;
    localparam int SQRT_ITER = ROOT_W;
    localparam int DIV_ITER  = QUOT_W;

    localparam logic MODE_SQRT = 1'b0;
    localparam logic MODE_DIV  = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } sqdiv_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqdiv_stat_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if ((&v[SUM_W-1:POS_W-1]) || !(|v[SUM_W-1:POS_W-1]))
            r = v[POS_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(POS_W-1){1'b0}}};
        else
            r = {1'b0, {(POS_W-1){1'b1}}};
        return r;
    endfunction

endpackage

FILE: src/smvs_if.sv
// Item and result channel interfaces of the spring mass step unit
interface smvs_item_if;
    import smvs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [POS_W-1:0]   link_x;
    logic signed [POS_W-1:0]   link_y;
    logic [K_W-1:0]            stiffness;
    logic [REST_W-1:0]         rest_length;

    modport source (output valid, op, link_x, link_y, stiffness, rest_length, input ready);
    modport sink (input valid, op, link_x, link_y, stiffness, rest_length, output ready);
endinterface

interface smvs_result_if;
    import smvs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   vel_x;
    logic signed [POS_W-1:0]   vel_y;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

FILE: src/smvs_mul.sv
// Shared signed multiplier with registered product
module smvs_mul (
    input  logic                                clk,
    input  logic signed [smvs_pkg::MUL_A_W-1:0] a,
    input  logic signed [smvs_pkg::MUL_B_W-1:0] b,
    output logic signed [smvs_pkg::PROD_W-1:0]  prod
);
    import smvs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

FILE: src/smvs_sqdiv.sv
// Shared compare-subtract unit: bit-serial square root and division
`include "spring_mass_velocity_step_unit_macros.svh"
module smvs_sqdiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smvs_pkg::sqdiv_req_t          req,
    input  logic [smvs_pkg::RAD_W-1:0]    radicand,
    input  logic [smvs_pkg::ROOT_W-1:0]   divisor,
    input  logic [smvs_pkg::ROOT_W-1:0]   mag,
    output smvs_pkg::sqdiv_stat_t         stat,
    output logic [smvs_pkg::ROOT_W-1:0]   result
);
    import smvs_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic                mode_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [RAD_W-1:0]    src_reg;
    logic [ROOT_W-1:0]   res_reg;
    logic [ROOT_W-1:0]   dsr_reg;

    logic [REM_W+1:0]    cand;
    logic [REM_W+1:0]    trial;
    logic [REM_W+2:0]    diff;
    logic                ge;

    always_comb
    begin
        if (mode_reg == MODE_SQRT)
        begin
            cand  = {rem_reg, src_reg[RAD_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W){1'b0}}, res_reg, 2'b01};
        end
        else
        begin
            cand  = {1'b0, rem_reg, src_reg[RAD_W-1]};
            trial = {{(REM_W+2-ROOT_W){1'b0}}, dsr_reg};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[REM_W+2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_SQRT;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                cnt_reg  <= (req.mode == MODE_SQRT) ? CNT_W'(SQRT_ITER - 1)
                                                    : CNT_W'(DIV_ITER - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            res_reg <= '0;
            dsr_reg <= divisor;
            if (req.mode == MODE_SQRT)
            begin
                rem_reg <= '0;
                src_reg <= radicand;
            end
            else
            begin
                rem_reg <= REM_W'(mag[ROOT_W-1:1]);
                src_reg <= {mag[0], {(RAD_W-1){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
            src_reg <= (mode_reg == MODE_SQRT) ? {src_reg[RAD_W-3:0], 2'b00}
                                               : {src_reg[RAD_W-2:0], 1'b0};
            res_reg <= {res_reg[ROOT_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

    `SMVS_ASSERT_NOW(a_start_when_free, clk, rst_n, req.start, !busy_reg, "start while busy")
    `SMVS_ASSERT_NOW(a_done_after_busy, clk, rst_n, done_reg, $past(busy_reg) && !busy_reg, "done without run")
    `SMVS_ASSERT_NOW(a_busy_from_start, clk, rst_n, $rose(busy_reg), $past(req.start), "busy without start")
endmodule

FILE: src/spring_mass_velocity_step_unit.sv
// Link item: from transfer to result valid it runs the difference, both squares, k*dt, the bit-serial
// square root and two divisions on the shared compare-subtract unit; at zero distance no division runs.
// Advance, reload and unused-op items bypass that unit; a result still held by the receiver stalls staging.
// One item at a time: the next transfer is taken once the result is staged and the unit is idle again.
// Reset clears position and velocity to zero, step_time to 1092 and start
// registers to zero; the result register is empty after reset.
`include "spring_mass_velocity_step_unit_macros.svh"
module spring_mass_velocity_step_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [smvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smvs_pkg::CFG_DATA_W-1:0]    cfg_data,
    smvs_item_if.sink                          item,
    smvs_result_if.source                      result
);
    import smvs_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
    localparam logic [ST_W-1:0] ST_L_DIFF   = 5'd1;
    localparam logic [ST_W-1:0] ST_L_SQX    = 5'd2;
    localparam logic [ST_W-1:0] ST_L_SQY    = 5'd3;
    localparam logic [ST_W-1:0] ST_L_KDT    = 5'd4;
    localparam logic [ST_W-1:0] ST_L_ROOTGO = 5'd5;
    localparam logic [ST_W-1:0] ST_L_ROOT   = 5'd6;
    localparam logic [ST_W-1:0] ST_L_DIVX   = 5'd7;
    localparam logic [ST_W-1:0] ST_L_DIVY   = 5'd8;
    localparam logic [ST_W-1:0] ST_L_EX     = 5'd9;
    localparam logic [ST_W-1:0] ST_L_EY     = 5'd10;
    localparam logic [ST_W-1:0] ST_L_VX     = 5'd11;
    localparam logic [ST_W-1:0] ST_L_VY     = 5'd12;
    localparam logic [ST_W-1:0] ST_L_VDONE  = 5'd13;
    localparam logic [ST_W-1:0] ST_A_MULX   = 5'd14;
    localparam logic [ST_W-1:0] ST_A_MULY   = 5'd15;
    localparam logic [ST_W-1:0] ST_A_ADDY   = 5'd16;
    localparam logic [ST_W-1:0] ST_RELOAD   = 5'd17;
    localparam logic [ST_W-1:0] ST_FINISH   = 5'd18;

    logic [ST_W-1:0]            state_reg;
    logic [ST_W-1:0]            state_next;

    logic [DT_W-1:0]            step_time_reg;
    logic signed [POS_W-1:0]    start_x_reg;
    logic signed [POS_W-1:0]    start_y_reg;

    logic signed [POS_W-1:0]    px_reg;
    logic signed [POS_W-1:0]    py_reg;
    logic signed [POS_W-1:0]    vx_reg;
    logic signed [POS_W-1:0]    vy_reg;

    logic signed [POS_W-1:0]    lx_reg;
    logic signed [POS_W-1:0]    ly_reg;
    logic [K_W-1:0]             k_reg;
    logic [REST_W-1:0]          rest_reg;
    logic signed [POS_W-1:0]    dx_reg;
    logic signed [POS_W-1:0]    dy_reg;
    logic [RAD_W-1:0]           acc_reg;
    logic [KDT_W-1:0]           kdt_reg;
    logic [ROOT_W-1:0]          dist_reg;
    logic signed [EXT_W-1:0]    ext_reg;
    logic signed [UNIT_W-1:0]   ux_reg;
    logic signed [UNIT_W-1:0]   uy_reg;
    logic signed [MUL_A_W-1:0]  ex_reg;
    logic signed [MUL_A_W-1:0]  ey_reg;

    logic                       res_valid_reg;
    logic signed [POS_W-1:0]    res_px_reg;
    logic signed [POS_W-1:0]    res_py_reg;
    logic signed [POS_W-1:0]    res_vx_reg;
    logic signed [POS_W-1:0]    res_vy_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SUM_W-1:0]    prod_dt;

    sqdiv_req_t                 sq_req;
    sqdiv_stat_t                sq_stat;
    logic [ROOT_W-1:0]          sq_result;
    logic [ROOT_W-1:0]          sq_divisor;
    logic [ROOT_W-1:0]          sq_mag;
    logic [ROOT_W-1:0]          abs_dx;
    logic [ROOT_W-1:0]          abs_dy;
    logic [UNIT_W-1:0]          quot;

    logic                       take_item;
    logic                       load_result;

    assign take_item   = item.valid && item.ready;
    assign load_result = (state_reg == ST_FINISH) && (!res_valid_reg || result.ready);
    assign prod_dt     = prod[PROD_W-1:DT_FRAC];
    assign abs_dx      = dx_reg[POS_W-1] ? ROOT_W'(-dx_reg) : ROOT_W'(dx_reg);
    assign abs_dy      = dy_reg[POS_W-1] ? ROOT_W'(-dy_reg) : ROOT_W'(dy_reg);
    assign quot        = UNIT_W'(sq_result[QUOT_W-1:0]);

    smvs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    smvs_sqdiv u_sqdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (sq_req),
        .radicand (acc_reg),
        .divisor  (sq_divisor),
        .mag      (sq_mag),
        .stat     (sq_stat),
        .result   (sq_result)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_L_SQX:
            begin
                mul_a = MUL_A_W'(dx_reg);
                mul_b = MUL_B_W'(dx_reg);
            end
            ST_L_SQY:
            begin
                mul_a = MUL_A_W'(dy_reg);
                mul_b = MUL_B_W'(dy_reg);
            end
            ST_L_KDT:
            begin
                mul_a = MUL_A_W'(k_reg);
                mul_b = MUL_B_W'(step_time_reg);
            end
            ST_L_EX:
            begin
                mul_a = ext_reg;
                mul_b = MUL_B_W'(ux_reg);
            end
            ST_L_EY:
            begin
                mul_a = ext_reg;
                mul_b = MUL_B_W'(uy_reg);
            end
            ST_L_VX:
            begin
                mul_a = ex_reg;
                mul_b = MUL_B_W'(kdt_reg);
            end
            ST_L_VY:
            begin
                mul_a = ey_reg;
                mul_b = MUL_B_W'(kdt_reg);
            end
            ST_A_MULX:
            begin
                mul_a = MUL_A_W'(vx_reg);
                mul_b = MUL_B_W'(step_time_reg);
            end
            ST_A_MULY:
            begin
                mul_a = MUL_A_W'(vy_reg);
                mul_b = MUL_B_W'(step_time_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        sq_req.start = 1'b0;
        sq_req.mode  = MODE_SQRT;
        sq_divisor   = dist_reg;
        sq_mag       = abs_dy;
        case (state_reg)
            ST_L_ROOTGO:
            begin
                sq_req.start = 1'b1;
            end
            ST_L_ROOT:
            begin
                sq_req.start = sq_stat.done && (sq_result != '0);
                sq_req.mode  = MODE_DIV;
                sq_divisor   = sq_result;
                sq_mag       = abs_dx;
            end
            ST_L_DIVX:
            begin
                sq_req.start = sq_stat.done;
                sq_req.mode  = MODE_DIV;
            end
            default:
            begin
                sq_req.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_item)
                begin
                    unique case (item.op)
                        OP_LINK:    state_next = ST_L_DIFF;
                        OP_ADVANCE: state_next = ST_A_MULX;
                        OP_RELOAD:  state_next = ST_RELOAD;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_L_DIFF:   state_next = ST_L_SQX;
            ST_L_SQX:    state_next = ST_L_SQY;
            ST_L_SQY:    state_next = ST_L_KDT;
            ST_L_KDT:    state_next = ST_L_ROOTGO;
            ST_L_ROOTGO: state_next = ST_L_ROOT;
            ST_L_ROOT:
            begin
                if (sq_stat.done)
                    state_next = (sq_result == '0) ? ST_FINISH : ST_L_DIVX;
            end
            ST_L_DIVX:
            begin
                if (sq_stat.done)
                    state_next = ST_L_DIVY;
            end
            ST_L_DIVY:
            begin
                if (sq_stat.done)
                    state_next = ST_L_EX;
            end
            ST_L_EX:     state_next = ST_L_EY;
            ST_L_EY:     state_next = ST_L_VX;
            ST_L_VX:     state_next = ST_L_VY;
            ST_L_VY:     state_next = ST_L_VDONE;
            ST_L_VDONE:  state_next = ST_FINISH;
            ST_A_MULX:   state_next = ST_A_MULY;
            ST_A_MULY:   state_next = ST_A_ADDY;
            ST_A_ADDY:   state_next = ST_FINISH;
            ST_RELOAD:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (load_result)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            step_time_reg <= STEP_TIME_RESET;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_result)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_STEP_TIME: step_time_reg <= cfg_data[DT_W-1:0];
                    CFG_START_X:   start_x_reg   <= cfg_data;
                    CFG_START_Y:   start_y_reg   <= cfg_data;
                    default:       ;
                endcase
            end

            case (state_reg)
                ST_L_VY:    vx_reg <= sat32(SUM_W'(vx_reg) + prod_dt);
                ST_L_VDONE: vy_reg <= sat32(SUM_W'(vy_reg) + prod_dt);
                ST_A_MULY:  px_reg <= sat32(SUM_W'(px_reg) + prod_dt);
                ST_A_ADDY:  py_reg <= sat32(SUM_W'(py_reg) + prod_dt);
                ST_RELOAD:
                begin
                    px_reg <= start_x_reg;
                    py_reg <= start_y_reg;
                    vx_reg <= '0;
                    vy_reg <= '0;
                end
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            lx_reg   <= item.link_x;
            ly_reg   <= item.link_y;
            k_reg    <= item.stiffness;
            rest_reg <= item.rest_length;
        end

        case (state_reg)
            ST_L_DIFF:
            begin
                dx_reg <= sat32(SUM_W'(lx_reg) - SUM_W'(px_reg));
                dy_reg <= sat32(SUM_W'(ly_reg) - SUM_W'(py_reg));
            end
            ST_L_SQY:    acc_reg <= prod[RAD_W-1:0];
            ST_L_KDT:    acc_reg <= acc_reg + prod[RAD_W-1:0];
            ST_L_ROOTGO: kdt_reg <= prod[KDT_SHIFT +: KDT_W];
            ST_L_ROOT:
            begin
                dist_reg <= sq_result;
                ext_reg  <= EXT_W'(sq_result) - EXT_W'(rest_reg);
            end
            ST_L_DIVX:   ux_reg <= dx_reg[POS_W-1] ? -quot : quot;
            ST_L_DIVY:   uy_reg <= dy_reg[POS_W-1] ? -quot : quot;
            ST_L_EY:     ex_reg <= prod[FRAC_BITS +: MUL_A_W];
            ST_L_VX:     ey_reg <= prod[FRAC_BITS +: MUL_A_W];
            default:     ;
        endcase

        if (load_result)
        begin
            res_px_reg <= px_reg;
            res_py_reg <= py_reg;
            res_vx_reg <= vx_reg;
            res_vy_reg <= vy_reg;
        end
    end

    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.pos_x = res_px_reg;
    assign result.pos_y = res_py_reg;
    assign result.vel_x = res_vx_reg;
    assign result.vel_y = res_vy_reg;

    `SMVS_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, take_item, !item.ready, "ready after transfer")
    `SMVS_ASSERT_NOW(a_done_in_wait, clk, rst_n, sq_stat.done, state_reg == ST_L_ROOT || state_reg == ST_L_DIVX || state_reg == ST_L_DIVY, "unit done outside wait")
    `SMVS_ASSERT_NOW(a_result_from_finish, clk, rst_n, $rose(res_valid_reg), $past(state_reg) == ST_FINISH, "result raised outside finish")
endmodule

FILE: test/tb_spring_mass_velocity_step_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the spring mass step unit with a point mass state tracker
module tb_spring_mass_velocity_step_unit;
    import smvs_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [POS_W-1:0] Q_MAX    = 32'sh7fffffff;
    localparam logic signed [POS_W-1:0] Q_MIN    = 32'sh80000000;
    localparam logic [K_W-1:0]          K_MAX    = '1;
    localparam logic [REST_W-1:0]       REST_MAX = '1;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [POS_W-1:0] link_x;
        logic signed [POS_W-1:0] link_y;
        logic [K_W-1:0]          stiffness;
        logic [REST_W-1:0]       rest_length;
    } mass_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
    } mass_state_t;

    class point_mass_tracker;
        longint      pos_x;
        longint      pos_y;
        longint      vel_x;
        longint      vel_y;
        longint      step_time;
        longint      start_x;
        longint      start_y;
        mass_state_t expected_states[$];
        int          errors;

        function new();
            step_time = longint'(STEP_TIME_RESET);
            start_x   = 0;
            start_y   = 0;
            pos_x     = 0;
            pos_y     = 0;
            vel_x     = 0;
            vel_y     = 0;
            errors    = 0;
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        static function longint unsigned isqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned bit_w;
            longint unsigned rem;
            root  = 0;
            rem   = n;
            bit_w = 64'd1 << 62;
            while (bit_w > rem)
                bit_w = bit_w >> 2;
            while (bit_w != 0)
            begin
                if (rem >= root + bit_w)
                begin
                    rem  = rem - (root + bit_w);
                    root = (root >> 1) + bit_w;
                end
                else
                    root = root >> 1;
                bit_w = bit_w >> 2;
            end
            return root;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] reg_index,
                                logic [CFG_DATA_W-1:0] data);
            case (reg_index)
                CFG_STEP_TIME: step_time = longint'(data[DT_W-1:0]);
                CFG_START_X:   start_x = longint'(signed'(data));
                CFG_START_Y:   start_y = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function void link_spring(mass_item_t it);
            longint          lx, ly, dx, dy, ux, uy, ext, kdt, ex, ey, k, rest;
            longint unsigned d2, sq, link_len, mx, my;
            lx   = longint'(it.link_x);
            ly   = longint'(it.link_y);
            k    = longint'(it.stiffness);
            rest = longint'(it.rest_length);
            dx   = clamp32(lx - pos_x);
            dy   = clamp32(ly - pos_y);
            d2   = dx * dx;
            sq   = dy * dy;
            d2   = d2 + sq;
            link_len = isqrt(d2);
            if (link_len == 0)
                return;
            mx = (dx < 0) ? -dx : dx;
            my = (dy < 0) ? -dy : dy;
            ux = (mx << FRAC_BITS) / link_len;
            uy = (my << FRAC_BITS) / link_len;
            if (dx < 0)
                ux = -ux;
            if (dy < 0)
                uy = -uy;
            ext   = link_len - rest;
            kdt   = (k * step_time) >>> KDT_SHIFT;
            ex    = (ext * ux) >>> FRAC_BITS;
            ey    = (ext * uy) >>> FRAC_BITS;
            vel_x = clamp32(vel_x + ((ex * kdt) >>> DT_FRAC));
            vel_y = clamp32(vel_y + ((ey * kdt) >>> DT_FRAC));
        endfunction

        function void note_item(mass_item_t it);
            mass_state_t s;
            case (it.op)
                OP_LINK: link_spring(it);
                OP_ADVANCE:
                begin
                    pos_x = clamp32(pos_x + ((vel_x * step_time) >>> DT_FRAC));
                    pos_y = clamp32(pos_y + ((vel_y * step_time) >>> DT_FRAC));
                end
                OP_RELOAD:
                begin
                    pos_x = start_x;
                    pos_y = start_y;
                    vel_x = 0;
                    vel_y = 0;
                end
                default: ;
            endcase
            s.pos_x = pos_x[POS_W-1:0];
            s.pos_y = pos_y[POS_W-1:0];
            s.vel_x = vel_x[POS_W-1:0];
            s.vel_y = vel_y[POS_W-1:0];
            expected_states.insert(expected_states.size(), s);
        endfunction

        function void check_state(mass_state_t got);
            mass_state_t want;
            if (expected_states.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: pos (%0d, %0d) vel (%0d, %0d)",
                             got.pos_x, got.pos_y, got.vel_x, got.vel_y);
                return;
            end
            want = expected_states.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.vel_x !== want.vel_x || got.vel_y !== want.vel_y)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"mismatch: expected pos (%0d, %0d) vel (%0d, %0d), ",
                              "got pos (%0d, %0d) vel (%0d, %0d)"},
                             want.pos_x, want.pos_y, want.vel_x, want.vel_y,
                             got.pos_x, got.pos_y, got.vel_x, got.vel_y);
            end
        endfunction
    endclass

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smvs_item_if   item_ch ();
    smvs_result_if result_ch ();

    point_mass_tracker tracker;
    bit                calm = 1'b0;
    bit                hold_off_request = 1'b0;
    int                idle_cycles = 0;

    spring_mass_velocity_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #5 clk = ~clk;

    function automatic mass_item_t make_item(input logic [OP_W-1:0] op,
                                             input logic signed [POS_W-1:0] lx,
                                             input logic signed [POS_W-1:0] ly,
                                             input logic [K_W-1:0] k,
                                             input logic [REST_W-1:0] rest);
        mass_item_t it;
        it.op          = op;
        it.link_x      = lx;
        it.link_y      = ly;
        it.stiffness   = k;
        it.rest_length = rest;
        return it;
    endfunction

    function automatic logic signed [POS_W-1:0] extreme_coord();
        case ($urandom_range(0, 2))
            0:       return Q_MAX;
            1:       return Q_MIN;
            default: return '0;
        endcase
    endfunction

    function automatic mass_item_t random_item();
        mass_item_t it;
        int         pick;
        longint     span;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.op = OP_LINK;
        else if (pick < 75)
            it.op = OP_ADVANCE;
        else if (pick < 90)
            it.op = OP_RELOAD;
        else
            it.op = OP_UNUSED;
        it.link_x = $urandom;
        it.link_y = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 9)
        begin
            span = longint'(1) << $urandom_range(0, 22);
            it.link_x = POS_W'(point_mass_tracker::clamp32(tracker.pos_x - span +
                               longint'($urandom_range(0, 32'(2 * span)))));
            span = longint'(1) << $urandom_range(0, 22);
            it.link_y = POS_W'(point_mass_tracker::clamp32(tracker.pos_y - span +
                               longint'($urandom_range(0, 32'(2 * span)))));
        end
        else if (pick < 11)
        begin
            it.link_x = tracker.pos_x[POS_W-1:0];
            it.link_y = tracker.pos_y[POS_W-1:0];
        end
        else if (pick >= 16)
        begin
            it.link_x = extreme_coord();
            it.link_y = extreme_coord();
        end
        case ($urandom_range(0, 9))
            0:       it.stiffness = '0;
            1:       it.stiffness = K_MAX;
            2, 3:    it.stiffness = K_W'($urandom_range(0, 255));
            default: it.stiffness = K_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       it.rest_length = '0;
            1:       it.rest_length = REST_MAX;
            2, 3, 4: it.rest_length = REST_W'($urandom_range(0, 1 << 22));
            default: it.rest_length = REST_W'($urandom);
        endcase
        return it;
    endfunction

    task automatic push_item(input mass_item_t it);
        item_ch.valid       = 1'b1;
        item_ch.op          = it.op;
        item_ch.link_x      = it.link_x;
        item_ch.link_y      = it.link_y;
        item_ch.stiffness   = it.stiffness;
        item_ch.rest_length = it.rest_length;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        tracker.note_item(it);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic wait_settled();
        item_ch.valid = 1'b0;
        while (tracker.expected_states.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_port(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [DT_W-1:0] dt,
                                input logic [POS_W-1:0] sx,
                                input logic [POS_W-1:0] sy);
        logic [CFG_DATA_W-1:0] dt_word;
        dt_word = $urandom;
        dt_word[DT_W-1:0] = dt;
        wait_settled();
        write_port(CFG_STEP_TIME, dt_word);
        write_port(CFG_START_X, sx);
        write_port(CFG_START_Y, sy);
        write_port(CFG_UNUSED, $urandom);
        cfg_write = 1'b0;
    endtask

    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else if (hold_off_request)
            begin
                // hold off long enough for the input side to back up
                result_ch.ready  = 1'b0;
                stall_left       = LONG_HOLD - 1;
                hold_off_request = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready = 1'b0;
                stall_left      = $urandom_range(0, 4);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        mass_state_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.pos_x = result_ch.pos_x;
            got.pos_y = result_ch.pos_y;
            got.vel_x = result_ch.vel_x;
            got.vel_y = result_ch.vel_y;
            tracker.check_state(got);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_spring_mass_velocity_step_unit: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        tracker = new();
        cfg_write           = 1'b0;
        cfg_index           = CFG_STEP_TIME;
        cfg_data            = '0;
        item_ch.valid       = 1'b0;
        item_ch.op          = OP_LINK;
        item_ch.link_x      = '0;
        item_ch.link_y      = '0;
        item_ch.stiffness   = '0;
        item_ch.rest_length = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        push_item(make_item(OP_LINK, '0, '0, K_MAX, '0));
        push_item(make_item(OP_UNUSED, $urandom, $urandom, K_W'($urandom),
                            REST_W'($urandom)));
        push_item(make_item(OP_LINK, Q_MAX, Q_MAX, K_MAX, '0));
        push_item(make_item(OP_LINK, Q_MIN, Q_MIN, K_MAX, REST_MAX));
        push_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
        push_item(make_item(OP_RELOAD, Q_MAX, Q_MIN, K_MAX, REST_MAX));

        // far corner with the largest step: drive velocity and position into saturation
        program_regs('1, Q_MIN, Q_MAX);
        push_item(make_item(OP_RELOAD, '0, '0, '0, '0));
        push_item(make_item(OP_LINK, Q_MAX, Q_MIN, K_MAX, '0));
        push_item(make_item(OP_LINK, Q_MAX, Q_MIN, K_MAX, '0));
        repeat (3) push_item(make_item(OP_ADVANCE, $urandom, $urandom, K_W'($urandom),
                                       REST_W'($urandom)));
        push_item(make_item(OP_LINK, '0, '0, '0, REST_MAX));
        push_item(make_item(OP_LINK, tracker.pos_x[POS_W-1:0], tracker.pos_y[POS_W-1:0],
                            K_MAX, '0));
        push_item(make_item(OP_UNUSED, Q_MIN, Q_MAX, '0, REST_MAX));

        program_regs('0, 32'sh00010000, -32'sh00020000);
        push_item(make_item(OP_RELOAD, '0, '0, '0, '0));
        push_item(make_item(OP_LINK, 32'sh00050000, '0, K_MAX, '0));
        push_item(make_item(OP_ADVANCE, '0, '0, '0, '0));

        program_regs(STEP_TIME_RESET, '0, '0);
        push_item(make_item(OP_RELOAD, '0, '0, '0, '0));
        push_item(make_item(OP_LINK, 32'sh00010000, '0, 16'h0100, '0));
        push_item(make_item(OP_LINK, 32'sh00030000, -32'sh00040000, 16'h1234, 31'h28000));
        push_item(make_item(OP_LINK, 32'sh00000001, 32'sh00000001, K_MAX, REST_MAX));
        push_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
        push_item(make_item(OP_ADVANCE, '0, '0, '0, '0));

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       program_regs(DT_W'($urandom), $urandom, $urandom);
                1:       program_regs('1, Q_MAX, Q_MIN);
                2:       program_regs(DT_W'($urandom_range(1, 4096)), '0, '0);
                3:       program_regs(16'd1, $urandom, $urandom);
                default: program_regs(STEP_TIME_RESET, $urandom_range(0, 1 << 20),
                                      -$urandom_range(0, 1 << 20));
            endcase
            if (phase == 2)
                hold_off_request = 1'b1;
            if (phase == PHASES - 1)
                calm = 1'b1;
            repeat (ITEMS_PER_PHASE) push_item(random_item());
        end

        wait_settled();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.errors == 0 && tracker.expected_states.size() == 0)
            $display("tb_spring_mass_velocity_step_unit: done, clean");
        else
            $display("tb_spring_mass_velocity_step_unit: done, errors");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/smvs_pkg.sv
src/smvs_if.sv
src/smvs_mul.sv
src/smvs_sqdiv.sv
src/spring_mass_velocity_step_unit.sv
test/tb_spring_mass_velocity_step_unit.sv
